>>> hw/rtl/ssc_pkg.sv
package ssc_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int STAT_W      = 16;
    localparam int MAG_W       = STAT_W + 1;
    localparam int SQ_W        = 31;
    localparam int SUM_W       = 37;
    localparam int RANK_W      = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int QDEPTH      = 4;

    typedef struct packed {
        logic [SQ_W-1:0] square;
        logic            last;
    } t_entry;

    typedef enum logic [1:0] {
        S_FILL = 2'b01,
        S_EMIT = 2'b10
    } t_state;

endpackage

>>> hw/rtl/sorted_square_cumsum.sv
// Sorted running sums of squared statistics.
// Input stream: one signed Q8.8 statistic per beat on s_axis_tdata, with
// s_axis_tlast on the final value of a vector. Each value is squared and
// placed into a row of compare cells kept in descending order, one beat
// per cycle while the row is filling. Beyond MaxLen held values further
// beats are dropped and the overflow flag of the run is set.
// Output stream: after a tlast beat, one beat per held square in rank order:
// tdata carries the sum of the rank+1 largest squares (unsigned Q21.16) and the rank,
// tuser the overflow flag, tlast the final beat of the run.
// The first result passes from the square register through the queue, the
// insert into the cell row and the output register.
// Emission runs at one rank per cycle while m_axis_tready does not stall it;
// the 4-entry queue absorbs input while the cell row is emitting.
// Reset clears the front register, the queue and the count and flag of the
// run. When m_axis_tready is low the result beat holds, emission pauses, and
// input backs up once the queue fills.
module sorted_square_cumsum #(
    parameter int MaxLen = ssc_pkg::MAX_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ssc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] stat_value
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ssc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [36:0] running_sum, [42:37] rank
    output logic                              m_axis_tuser,  // [0] overflowed
    output logic                              m_axis_tlast
);
    import ssc_pkg::*;

    logic               f_valid;
    logic               f_ready;
    t_entry             f_entry;
    logic               q_valid;
    logic               q_ready;
    t_entry             q_entry;
    logic [SUM_W-1:0]   b_sum;
    logic [RANK_W-1:0]  b_rank;

    ssc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (s_axis_tdata[STAT_W-1:0]),
        .i_last  (s_axis_tlast),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_entry (f_entry)
    );

    ssc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_entry (f_entry),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_entry (q_entry)
    );

    ssc_back #(.MaxLen(MaxLen)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_entry    (q_entry),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_sum      (b_sum),
        .o_rank     (b_rank),
        .o_overflow (m_axis_tuser),
        .o_end      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - SUM_W - RANK_W){1'b0}}, b_rank, b_sum};

endmodule

>>> hw/rtl/ssc_front.sv
module ssc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ssc_pkg::STAT_W-1:0]    i_stat,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ssc_pkg::t_entry               o_entry
);
    import ssc_pkg::*;

    logic               r_valid;
    t_entry             r_entry;
    logic [MAG_W-1:0]   ext;
    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] prod;

    // magnitude of the signed value, 0..32768
    assign ext     = {i_stat[STAT_W-1], i_stat};
    assign mag     = i_stat[STAT_W-1] ? (~ext + MAG_W'(1)) : ext;
    assign prod    = mag * mag;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_entry.square <= prod[SQ_W-1:0];
            r_entry.last   <= i_last;
        end
    end

endmodule

>>> hw/rtl/ssc_fifo.sv
module ssc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ssc_pkg::t_entry i_entry,
    output logic            o_valid,
    input  logic            i_ready,
    output ssc_pkg::t_entry o_entry
);
    import ssc_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_entry          r_slot [QDEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;

    assign o_ready = r_cnt != CW'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_slot[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(QDEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

endmodule

>>> hw/rtl/ssc_back.sv
module ssc_back #(
    parameter int MaxLen = ssc_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  ssc_pkg::t_entry              i_entry,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ssc_pkg::SUM_W-1:0]    o_sum,
    output logic [ssc_pkg::RANK_W-1:0]   o_rank,
    output logic                         o_overflow,
    output logic                         o_end
);
    import ssc_pkg::*;

    localparam int CW = $clog2(MaxLen + 1);
    localparam int IW = $clog2(MaxLen);

    t_state             r_state;
    logic [SQ_W-1:0]    r_cell [MaxLen];
    logic [CW-1:0]      r_count;
    logic               r_drop;
    logic [IW-1:0]      r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic               r_ov;
    logic [SUM_W-1:0]   r_osum;
    logic [RANK_W-1:0]  r_orank;
    logic               r_oflag;
    logic               r_oend;

    logic [MaxLen-1:0]  ge;
    logic [SQ_W-1:0]    ins [MaxLen];
    logic               full;
    logic               pop;
    logic               emit_go;
    logic               emit_end;
    logic [SUM_W-1:0]   n_sum;

    assign full     = r_count == CW'(MaxLen);
    assign o_ready  = r_state == S_FILL;
    assign pop      = o_ready && i_valid;
    assign emit_go  = (r_state == S_EMIT) && (!r_ov || i_ready);
    assign emit_end = CW'(r_idx) == (r_count - CW'(1));
    assign n_sum    = r_sum + SUM_W'(r_cell[0]);

    // each cell keeps, takes the new square, or takes its upper neighbor
    always_comb begin
        for (int i = 0; i < MaxLen; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_cell[i] >= i_entry.square);
        end
        ins[0] = ge[0] ? r_cell[0] : i_entry.square;
        for (int i = 1; i < MaxLen; i++) begin
            if (ge[i]) begin
                ins[i] = r_cell[i];
            end else if (ge[i-1]) begin
                ins[i] = i_entry.square;
            end else begin
                ins[i] = r_cell[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && !full) begin
            for (int i = 0; i < MaxLen; i++) begin
                r_cell[i] <= ins[i];
            end
        end else if (emit_go) begin
            for (int i = 0; i < MaxLen - 1; i++) begin
                r_cell[i] <= r_cell[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_FILL: begin
                    if (pop) begin
                        if (full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_entry.last) begin
                            r_state <= S_EMIT;
                            r_idx   <= '0;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_idx <= r_idx + IW'(1);
                        if (emit_end) begin
                            r_state <= S_FILL;
                            r_count <= '0;
                            r_drop  <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_entry.last) begin
            r_sum <= '0;
        end else if (emit_go) begin
            r_sum <= n_sum;
        end
        if (emit_go) begin
            r_osum  <= n_sum;
            r_orank <= RANK_W'(r_idx);
            r_oflag <= r_drop;
            r_oend  <= emit_end;
        end
    end

    assign o_valid    = r_ov;
    assign o_sum      = r_osum;
    assign o_rank     = r_orank;
    assign o_overflow = r_oflag;
    assign o_end      = r_oend;

endmodule

>>> hw/rtl/ssc_checker.sv
module ssc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [ssc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              m_axis_tuser,
    input  logic                              m_axis_tlast
);
    import ssc_pkg::*;

    logic               acc;
    logic               r_in_run;
    logic [SUM_W-1:0]   r_prev_sum;
    logic [RANK_W-1:0]  r_prev_rank;
    logic               r_prev_user;

    assign acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (acc) begin
            r_in_run <= !m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_prev_sum  <= m_axis_tdata[SUM_W-1:0];
            r_prev_rank <= m_axis_tdata[SUM_W+RANK_W-1:SUM_W];
            r_prev_user <= m_axis_tuser;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_first_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !r_in_run |-> m_axis_tdata[SUM_W+RANK_W-1:SUM_W] == '0)
        else $error("run does not start at rank zero");

    a_next_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_in_run |-> m_axis_tdata[SUM_W+RANK_W-1:SUM_W] == r_prev_rank + RANK_W'(1))
        else $error("rank did not advance by one");

    a_sum_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_in_run |-> m_axis_tdata[SUM_W-1:0] >= r_prev_sum && m_axis_tuser == r_prev_user)
        else $error("running sum fell or overflow flag changed within a run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind sorted_square_cumsum ssc_checker u_ssc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> bench/sorted_square_cumsum_checker.sv
`timescale 1ns / 1ps
module sorted_square_cumsum_checker #(
    parameter int MaxLen = ssc_pkg::MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [ssc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] stat_value
    input  logic                             s_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ssc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [36:0] running_sum, [42:37] rank
    input  logic                             m_axis_tuser,  // [0] overflowed
    input  logic                             m_axis_tlast,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int SqW   = ssc_pkg::SQ_W;
    localparam int SumW  = ssc_pkg::SUM_W;
    localparam int RankW = ssc_pkg::RANK_W;
    localparam int StatW = ssc_pkg::STAT_W;
    localparam int MagW  = ssc_pkg::MAG_W;

    typedef struct packed {
        logic [SumW-1:0]  running_sum;
        logic [RankW-1:0] rank;
        logic             overflowed;
        logic             end_of_run;
    } t_cumsum;

    logic [SqW-1:0] square_row [MaxLen];
    int             held_squares = 0;
    logic           dropped_any = 1'b0;
    t_cumsum        cumsum_q [$];
    int             fails = 0;

    function automatic logic [SqW-1:0] square_of(input logic [StatW-1:0] v);
        logic [MagW-1:0]   mag;
        logic [2*MagW-1:0] prod;
        mag  = v[StatW-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        prod = mag * mag;
        return prod[SqW-1:0];
    endfunction

    task automatic take_stat(input logic [StatW-1:0] v, input logic last);
        logic [SqW-1:0]  sq;
        logic [SumW-1:0] sum;
        t_cumsum         c;
        int              pos;
        int              i;
        int              r;
        sq = square_of(v);
        if (held_squares < MaxLen) begin
            pos = 0;
            while (pos < held_squares && square_row[pos] >= sq)
                pos++;
            for (i = held_squares; i > pos; i--)
                square_row[i] = square_row[i-1];
            square_row[pos] = sq;
            held_squares++;
        end else begin
            dropped_any = 1'b1;
        end
        if (last) begin
            sum = '0;
            for (r = 0; r < held_squares; r++) begin
                sum = sum + SumW'(square_row[r]);
                c.running_sum = sum;
                c.rank        = RankW'(r);
                c.overflowed  = dropped_any;
                c.end_of_run  = (r == held_squares - 1);
                cumsum_q.push_back(c);
            end
            held_squares = 0;
            dropped_any  = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cumsum want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                take_stat(s_axis_tdata[StatW-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (cumsum_q.size() == 0) begin
                    $error("result beat with no sum expected: tdata %0h", m_axis_tdata);
                    fails++;
                end else begin
                    want = cumsum_q.pop_front();
                    if (m_axis_tdata[SumW-1:0] !== want.running_sum) begin
                        $error("running_sum mismatch: expected %0d, actual %0d",
                               want.running_sum, m_axis_tdata[SumW-1:0]);
                        fails++;
                    end
                    if (m_axis_tdata[SumW+RankW-1:SumW] !== want.rank) begin
                        $error("rank mismatch: expected %0d, actual %0d",
                               want.rank, m_axis_tdata[SumW+RankW-1:SumW]);
                        fails++;
                    end
                    if (m_axis_tuser !== want.overflowed) begin
                        $error("overflowed mismatch: expected %0b, actual %0b",
                               want.overflowed, m_axis_tuser);
                        fails++;
                    end
                    if (m_axis_tlast !== want.end_of_run) begin
                        $error("end_of_run mismatch: expected %0b, actual %0b",
                               want.end_of_run, m_axis_tlast);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= cumsum_q.size();
    end

    final begin
        if (cumsum_q.size() != 0)
            $error("%0d expected sums never arrived", cumsum_q.size());
    end

endmodule

>>> bench/sorted_square_cumsum_tb.sv
`timescale 1ns / 1ps
module sorted_square_cumsum_tb;

    localparam int MaxLen      = ssc_pkg::MAX_LEN_DEF;
    localparam int CycleLimit  = 400000;
    localparam int RandomItems = 20;
    localparam int HoldCycles  = 300;
    localparam int DirCount    = 21;

    // {last, stat_value}
    localparam logic [16:0] DIRECTED [DirCount] = '{
        {1'b1, 16'h7FFF}, {1'b1, 16'h8000}, {1'b1, 16'h0000},
        {1'b0, 16'hFFFF}, {1'b0, 16'h0001}, {1'b0, 16'h8001}, {1'b1, 16'h7FFF},
        {1'b0, 16'h0100}, {1'b0, 16'hFF00}, {1'b0, 16'h0200}, {1'b0, 16'h0000},
        {1'b0, 16'h8000}, {1'b1, 16'h0080},
        {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b0, 16'h8000},
        {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b1, 16'h8000}
    };

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ssc_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;   // [15:0] stat_value
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ssc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;        // [36:0] running_sum, [42:37] rank
    logic                             m_axis_tuser;        // [0] overflowed
    logic                             m_axis_tlast;

    int   fail_count;
    int   pending_sums;
    int   cycles = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) cycles <= cycles + 1;

    sorted_square_cumsum #(
        .MaxLen(MaxLen)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    sorted_square_cumsum_checker #(
        .MaxLen(MaxLen)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_sums)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_stat(input logic [15:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom_range(0, 65535));
            5: begin
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            6, 7: return 16'($urandom_range(0, 511) - 256);
            8: return prev;
            default: return 16'(-prev);
        endcase
    endfunction

    task automatic send_stat(input logic [15:0] v, input logic last, input logic idle);
        int gap;
        gap = idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_run(input int len, input logic idle);
        logic [15:0] v;
        int          i;
        v = 16'($urandom_range(0, 65535));
        for (i = 0; i < len; i++) begin
            v = pick_stat(v);
            send_stat(v, i == len - 1, idle);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums != 0) @(posedge i_clk);
    endtask

    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin : rx_idle
                int gap;
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        while (cycles < CycleLimit) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int k;
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DirCount; k++)
            send_stat(DIRECTED[k][15:0], DIRECTED[k][16], 1'b1);
        wait_drained();

        // fill the row exactly, then overrun it with the marked beat dropped
        hold_req = 1'b1;
        send_run(MaxLen, 1'b0);
        send_run(MaxLen + 3, 1'b1);
        wait_drained();

        k = 0;
        while (k < RandomItems) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(1, 8);
            send_run(len, 1'b1);
            k += len;
        end
        wait_drained();
        repeat (16) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_front.sv
hw/rtl/ssc_fifo.sv
hw/rtl/ssc_back.sv
hw/rtl/sorted_square_cumsum.sv
hw/rtl/ssc_checker.sv
bench/sorted_square_cumsum_checker.sv
bench/sorted_square_cumsum_tb.sv
